// ===== design/ric_pkg.sv =====
`default_nettype none
package ric_pkg;

   // Sizes of the state.
   localparam int MEM_WORDS = 16384;
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam int NUM_REGS  = 32;
   localparam int REG_AW    = 5;
   localparam int RSPQ_DEPTH = 4;
   localparam int RSPQ_AW    = $clog2(RSPQ_DEPTH);

   // Major opcodes, instruction bits 6..2.
   localparam logic [4:0] OP_LOAD   = 5'b00000;
   localparam logic [4:0] OP_FENCE  = 5'b00011;
   localparam logic [4:0] OP_IMM    = 5'b00100;
   localparam logic [4:0] OP_AUIPC  = 5'b00101;
   localparam logic [4:0] OP_STORE  = 5'b01000;
   localparam logic [4:0] OP_REG    = 5'b01100;
   localparam logic [4:0] OP_LUI    = 5'b01101;
   localparam logic [4:0] OP_BRANCH = 5'b11000;
   localparam logic [4:0] OP_JALR   = 5'b11001;
   localparam logic [4:0] OP_JAL    = 5'b11011;
   localparam logic [4:0] OP_SYSTEM = 5'b11100;

   // Memory access sizes.
   localparam logic [2:0] F3_B  = 3'd0;
   localparam logic [2:0] F3_H  = 3'd1;
   localparam logic [2:0] F3_W  = 3'd2;
   localparam logic [2:0] F3_BU = 3'd4;
   localparam logic [2:0] F3_HU = 3'd5;

   // ALU operations.
   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   // Branch conditions.
   localparam logic [2:0] BR_EQ  = 3'd0;
   localparam logic [2:0] BR_NE  = 3'd1;
   localparam logic [2:0] BR_LT  = 3'd4;
   localparam logic [2:0] BR_GE  = 3'd5;
   localparam logic [2:0] BR_LTU = 3'd6;
   localparam logic [2:0] BR_GEU = 3'd7;

   localparam logic [6:0] F7_ZERO = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // Status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ILLEGAL = 2'd1;
   localparam logic [1:0] ST_SYSTEM  = 2'd2;

   typedef struct packed {
      logic [31:0]       next_pc;
      logic [1:0]        status;
      logic              wr;
      logic [REG_AW-1:0] rd;
      logic [31:0]       val;
      logic              is_load;
      logic              is_store;
      logic [2:0]        f3;
      logic [1:0]        lane;
      logic [MEM_AW-1:0] mem_idx;
      logic [31:0]       store_data;
   } ric_exec_type;

   typedef struct packed {
      logic [31:0]       next_pc;
      logic [REG_AW-1:0] dest_index;
      logic [31:0]       dest_value;
      logic              dest_written;
      logic [1:0]        exec_status;
   } ric_rsp_type;

endpackage
`default_nettype wire

// ===== design/ric_regfile.sv =====
`default_nettype none
module ric_regfile (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [ric_pkg::REG_AW-1:0] rd_a_idx,
   input  wire logic [ric_pkg::REG_AW-1:0] rd_b_idx,
   output logic [31:0]                     rd_a_data,
   output logic [31:0]                     rd_b_data,
   input  wire logic                      wr_en,
   input  wire logic [ric_pkg::REG_AW-1:0] wr_idx,
   input  wire logic [31:0]               wr_data
);
   import ric_pkg::*;

   logic [31:0]         regs [NUM_REGS];
   logic [NUM_REGS-1:0] valid_ff;
   logic [31:0]         a_q_ff, b_q_ff;
   logic                a_ok_ff, b_ok_ff;

   // An entry never written reads as zero; x0 is never written.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en && ({1'b0, wr_idx} < (REG_AW+1)'(NUM_REGS))) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   // Synchronous storage with two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en && ({1'b0, wr_idx} < (REG_AW+1)'(NUM_REGS))) begin
         regs[wr_idx] <= wr_data;
      end
      a_q_ff  <= regs[rd_a_idx];
      b_q_ff  <= regs[rd_b_idx];
      a_ok_ff <= ({1'b0, rd_a_idx} < (REG_AW+1)'(NUM_REGS)) && valid_ff[rd_a_idx];
      b_ok_ff <= ({1'b0, rd_b_idx} < (REG_AW+1)'(NUM_REGS)) && valid_ff[rd_b_idx];
   end

   assign rd_a_data = a_ok_ff ? a_q_ff : 32'd0;
   assign rd_b_data = b_ok_ff ? b_q_ff : 32'd0;

endmodule
`default_nettype wire

// ===== design/ric_dmem.sv =====
`default_nettype none
module ric_dmem (
   input  wire logic                      clock,
   input  wire logic                      reset,
   output logic                           busy,
   input  wire logic [ric_pkg::MEM_AW-1:0] rd_idx,
   output logic [31:0]                    rd_data,
   input  wire logic                      wr_en,
   input  wire logic [ric_pkg::MEM_AW-1:0] wr_idx,
   input  wire logic [31:0]               wr_data
);
   import ric_pkg::*;

   logic [31:0]       mem [MEM_WORDS];
   logic              busy_ff, busy_in;
   logic [MEM_AW-1:0] clr_ff, clr_in;
   logic              we;
   logic [MEM_AW-1:0] widx;
   logic [31:0]       wdata;

   // Clearing sweep after reset, one word a cycle.
   always_comb begin
      busy_in = busy_ff;
      clr_in  = clr_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == MEM_AW'(MEM_WORDS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         clr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         clr_ff  <= clr_in;
      end
   end

   assign we    = busy_ff || wr_en;
   assign widx  = busy_ff ? clr_ff : wr_idx;
   assign wdata = busy_ff ? 32'd0 : wr_data;

   // Single write port, registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[widx] <= wdata;
      end
      rd_data <= mem[rd_idx];
   end

   assign busy = busy_ff;

endmodule
`default_nettype wire

// ===== design/ric_exec.sv =====
`default_nettype none
module ric_exec (
   input  wire logic [31:0]     instr,
   input  wire logic [31:0]     pc,
   input  wire logic [31:0]     op_a,
   input  wire logic [31:0]     op_b,
   output ric_pkg::ric_exec_type res
);
   import ric_pkg::*;

   logic [4:0]  op;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [4:0]  rd;
   logic [4:0]  sh;
   logic [31:0] imm_i, imm_s, imm_b, imm_j, addr, rhs, alu, pc4;
   logic        lt_s, lt_u, take;

   assign op    = instr[6:2];
   assign rd    = instr[11:7];
   assign f3    = instr[14:12];
   assign f7    = instr[31:25];
   assign imm_i = {{20{instr[31]}}, instr[31:20]};
   assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
   assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
   assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
   assign pc4   = pc + 32'd4;
   assign rhs   = (op == OP_REG) ? op_b : imm_i;
   assign sh    = rhs[4:0];
   assign lt_s  = $signed(op_a) < $signed(rhs);
   assign lt_u  = op_a < rhs;
   assign addr  = op_a + ((op == OP_STORE) ? imm_s : imm_i);

   // Shared ALU for register and immediate forms.
   always_comb begin
      unique case (f3)
         F3_ADD:  alu = (op == OP_REG && f7 == F7_ALT) ? op_a - rhs : op_a + rhs;
         F3_SLL:  alu = op_a << sh;
         F3_SLT:  alu = {31'd0, lt_s};
         F3_SLTU: alu = {31'd0, lt_u};
         F3_XOR:  alu = op_a ^ rhs;
         F3_SR:   alu = (f7 == F7_ALT) ? 32'($signed(op_a) >>> sh) : op_a >> sh;
         F3_OR:   alu = op_a | rhs;
         default: alu = op_a & rhs;
      endcase
   end

   // Branch condition.
   always_comb begin
      unique case (f3)
         BR_EQ:   take = (op_a == op_b);
         BR_NE:   take = (op_a != op_b);
         BR_LT:   take = $signed(op_a) < $signed(op_b);
         BR_GE:   take = !($signed(op_a) < $signed(op_b));
         BR_LTU:  take = op_a < op_b;
         BR_GEU:  take = op_a >= op_b;
         default: take = 1'b0;
      endcase
   end

   // Decode, legality and result selection.
   always_comb begin
      res            = '0;
      res.next_pc    = pc4;
      res.rd         = rd;
      res.f3         = f3;
      res.lane       = addr[1:0];
      res.mem_idx    = addr[MEM_AW+1:2];
      res.store_data = op_b;
      unique case (op)
         OP_LOAD: begin
            if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7) begin
               res.status = ST_ILLEGAL;
            end else begin
               res.is_load = 1'b1;
               res.wr      = 1'b1;
            end
         end
         OP_FENCE, OP_SYSTEM: res.status = ST_SYSTEM;
         OP_IMM: begin
            if ((f3 == F3_SLL && f7 != F7_ZERO) ||
                (f3 == F3_SR && f7 != F7_ZERO && f7 != F7_ALT)) begin
               res.status = ST_ILLEGAL;
            end else begin
               res.val = alu;
               res.wr  = 1'b1;
            end
         end
         OP_AUIPC: begin
            res.val = pc + {instr[31:12], 12'd0};
            res.wr  = 1'b1;
         end
         OP_STORE: begin
            if (f3 > F3_W) begin
               res.status = ST_ILLEGAL;
            end else begin
               res.is_store = 1'b1;
            end
         end
         OP_REG: begin
            if (f7 != F7_ZERO && !(f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
               res.status = ST_ILLEGAL;
            end else begin
               res.val = alu;
               res.wr  = 1'b1;
            end
         end
         OP_LUI: begin
            res.val = {instr[31:12], 12'd0};
            res.wr  = 1'b1;
         end
         OP_BRANCH: begin
            if (f3 == 3'd2 || f3 == 3'd3) begin
               res.status = ST_ILLEGAL;
            end else if (take) begin
               res.next_pc = pc + imm_b;
            end
         end
         OP_JALR: begin
            if (f3 != 3'd0) begin
               res.status = ST_ILLEGAL;
            end else begin
               res.val     = pc4;
               res.wr      = 1'b1;
               res.next_pc = {addr[31:1], 1'b0};
            end
         end
         OP_JAL: begin
            res.val     = pc4;
            res.wr      = 1'b1;
            res.next_pc = pc + imm_j;
         end
         default: res.status = ST_ILLEGAL;
      endcase
      // A faulting instruction changes nothing.
      if (res.status != ST_OK) begin
         res.next_pc  = pc;
         res.wr       = 1'b0;
         res.is_load  = 1'b0;
         res.is_store = 1'b0;
      end
      if (rd == '0 || ({1'b0, rd} >= (REG_AW+1)'(NUM_REGS))) begin
         res.wr = 1'b0;
      end
   end

endmodule
`default_nettype wire

// ===== design/ric_rspq.sv =====
`default_nettype none
module ric_rspq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire ric_pkg::ric_rsp_type push_data,
   input  wire logic                 pop,
   output logic                      not_empty,
   output ric_pkg::ric_rsp_type      head,
   output logic [ric_pkg::RSPQ_AW:0] count
);
   import ric_pkg::*;

   ric_rsp_type        entry [RSPQ_DEPTH];
   logic [RSPQ_AW-1:0] wp_ff, rp_ff;
   logic [RSPQ_AW:0]   cnt_ff;

   // Pointers and fill count; the caller never pushes into a full queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + {{RSPQ_AW{1'b0}}, push} - {{RSPQ_AW{1'b0}}, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry[wp_ff] <= push_data;
      end
   end

   assign not_empty = (cnt_ff != '0);
   assign head      = entry[rp_ff];
   assign count     = cnt_ff;

endmodule
`default_nettype wire

// ===== design/rv32i_instruction_execute.sv =====
`default_nettype none
// RV32I executor: one instruction word per item, one result per item. The block runs as a
// three-stage pipeline (register file read, execute, memory and write back) and takes one
// item per cycle when not stalled, with forwarding around the register file and the data
// memory, so there is no interlock. Results wait in a four-entry queue; the input stalls
// when that queue and the pipeline together hold four items, and while the data memory is
// swept to zero, one word a cycle, after reset; no item is taken until the sweep is done.
module rv32i_instruction_execute (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_instr_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_next_pc,
   output logic [4:0]       rsp_dest_index,
   output logic [31:0]      rsp_dest_value,
   output logic             rsp_dest_written,
   output logic [1:0]       rsp_exec_status
);
   import ric_pkg::*;

   logic               accept, mem_busy, pop;
   logic               s1_valid_ff, s2_valid_ff, halted_ff, halted_in;
   logic [31:0]        s1_instr_ff, pc_ff, pc_in;
   ric_exec_type       ex, s1_res, s2_ff;
   logic               s2_fwd_ff, s2_fwd_in;
   logic [31:0]        wbuf_ff, rf_a, rf_b, op_a, op_b, dm_q, cur_word, load_val, s2_val;
   logic [31:0]        st_word;
   logic               wb_valid_ff;
   logic [REG_AW-1:0]  wb_rd_ff;
   logic [31:0]        wb_val_ff;
   logic               s2_wr;
   ric_rsp_type        rsp_in, head;
   logic [RSPQ_AW:0]   q_count;
   logic [RSPQ_AW+1:0] in_flight;

   // Input handshake: room counts items in flight plus queued results.
   assign in_flight = (RSPQ_AW+2)'(q_count) + (RSPQ_AW+2)'(s1_valid_ff)
                    + (RSPQ_AW+2)'(s2_valid_ff);
   assign req_stall = mem_busy || (in_flight >= (RSPQ_AW+2)'(RSPQ_DEPTH));
   assign accept    = req_valid && !req_stall;

   ric_regfile u_rf (
      .clock     (clock),
      .reset     (reset),
      .rd_a_idx  (req_instr_word[19:15]),
      .rd_b_idx  (req_instr_word[24:20]),
      .rd_a_data (rf_a),
      .rd_b_data (rf_b),
      .wr_en     (s2_wr),
      .wr_idx    (s2_ff.rd),
      .wr_data   (s2_val)
   );

   // Operand forwarding: the write in stage 2 first, then the write of the last cycle.
   function automatic logic [31:0] fwd(input logic [REG_AW-1:0] idx, input logic [31:0] q,
                                       input logic w2, input logic [REG_AW-1:0] rd2,
                                       input logic [31:0] v2, input logic w1,
                                       input logic [REG_AW-1:0] rd1, input logic [31:0] v1);
      logic [31:0] r;
      r = q;
      if (w2 && rd2 == idx) begin
         r = v2;
      end else if (w1 && rd1 == idx) begin
         r = v1;
      end
      return r;
   endfunction

   assign op_a = fwd(s1_instr_ff[19:15], rf_a, s2_wr, s2_ff.rd, s2_val,
                     wb_valid_ff, wb_rd_ff, wb_val_ff);
   assign op_b = fwd(s1_instr_ff[24:20], rf_b, s2_wr, s2_ff.rd, s2_val,
                     wb_valid_ff, wb_rd_ff, wb_val_ff);

   ric_exec u_exec (
      .instr (s1_instr_ff),
      .pc    (pc_ff),
      .op_a  (op_a),
      .op_b  (op_b),
      .res   (ex)
   );

   // Stage 1: a halted block reports the held pc and does nothing.
   always_comb begin
      s1_res    = ex;
      halted_in = halted_ff;
      pc_in     = pc_ff;
      if (halted_ff) begin
         s1_res         = '0;
         s1_res.next_pc = pc_ff;
         s1_res.mem_idx = ex.mem_idx;
      end
      if (s1_valid_ff) begin
         pc_in = s1_res.next_pc;
         if (s1_res.status != ST_OK) begin
            halted_in = 1'b1;
         end
      end
      s2_fwd_in = s2_valid_ff && s2_ff.is_store && (s2_ff.mem_idx == s1_res.mem_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         halted_ff   <= 1'b0;
         pc_ff       <= '0;
         wb_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         halted_ff   <= halted_in;
         pc_ff       <= pc_in;
         wb_valid_ff <= s2_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_instr_ff <= req_instr_word;
      end
      s2_ff     <= s1_res;
      s2_fwd_ff <= s2_fwd_in;
      wb_rd_ff  <= s2_ff.rd;
      wb_val_ff <= s2_val;
      if (s2_valid_ff && s2_ff.is_store) begin
         wbuf_ff <= st_word;
      end
   end

   ric_dmem u_dmem (
      .clock   (clock),
      .reset   (reset),
      .busy    (mem_busy),
      .rd_idx  (s1_res.mem_idx),
      .rd_data (dm_q),
      .wr_en   (s2_valid_ff && s2_ff.is_store),
      .wr_idx  (s2_ff.mem_idx),
      .wr_data (st_word)
   );

   // Stage 2: load extraction and store merge on the forwarded word.
   assign cur_word = s2_fwd_ff ? wbuf_ff : dm_q;

   always_comb begin
      logic [7:0]  by;
      logic [15:0] hw;
      by = cur_word[8*s2_ff.lane +: 8];
      hw = s2_ff.lane[1] ? cur_word[31:16] : cur_word[15:0];
      unique case (s2_ff.f3)
         F3_B:    load_val = {{24{by[7]}}, by};
         F3_BU:   load_val = {24'd0, by};
         F3_H:    load_val = {{16{hw[15]}}, hw};
         F3_HU:   load_val = {16'd0, hw};
         default: load_val = cur_word;
      endcase
      st_word = cur_word;
      unique case (s2_ff.f3)
         F3_B:    st_word[8*s2_ff.lane +: 8] = s2_ff.store_data[7:0];
         F3_H: begin
            if (s2_ff.lane[1]) begin
               st_word[31:16] = s2_ff.store_data[15:0];
            end else begin
               st_word[15:0] = s2_ff.store_data[15:0];
            end
         end
         default: st_word = s2_ff.store_data;
      endcase
   end

   assign s2_val = s2_ff.is_load ? load_val : s2_ff.val;
   assign s2_wr  = s2_valid_ff && s2_ff.wr;

   always_comb begin
      rsp_in              = '0;
      rsp_in.next_pc      = s2_ff.next_pc;
      rsp_in.exec_status  = s2_ff.status;
      rsp_in.dest_written = s2_ff.wr;
      if (s2_ff.wr) begin
         rsp_in.dest_index = s2_ff.rd;
         rsp_in.dest_value = s2_val;
      end
   end

   assign pop = rsp_valid && !rsp_stall;

   ric_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (rsp_in),
      .pop       (pop),
      .not_empty (rsp_valid),
      .head      (head),
      .count     (q_count)
   );

   assign rsp_next_pc      = head.next_pc;
   assign rsp_dest_index   = head.dest_index;
   assign rsp_dest_value   = head.dest_value;
   assign rsp_dest_written = head.dest_written;
   assign rsp_exec_status  = head.exec_status;

endmodule
`default_nettype wire

// ===== design/ric_checker.sv =====
`default_nettype none
module ric_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_next_pc,
   input wire logic [4:0]  rsp_dest_index,
   input wire logic [31:0] rsp_dest_value,
   input wire logic        rsp_dest_written,
   input wire logic [1:0]  rsp_exec_status
);
   import ric_pkg::*;

   // An item without write back carries zero destination fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_dest_written |-> rsp_dest_index == '0 && rsp_dest_value == '0)
      else $error("destination fields set without a write");

   // A faulting item never writes a register.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exec_status != ST_OK |-> !rsp_dest_written)
      else $error("faulting item reports a write");

   // x0 is never reported as written.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dest_written |-> rsp_dest_index != '0)
      else $error("write to x0 reported");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_next_pc))
      else $error("stalled result changed");

endmodule

bind rv32i_instruction_execute ric_checker u_ric_checker (.*);
`default_nettype wire

// ===== sim/tb_rv32i_instruction_execute.sv =====
`default_nettype none
module tb_rv32i_instruction_execute;
   import ric_pkg::*;

   localparam int WATCHDOG_LIMIT = 60000;
   localparam int HOLD_CYCLES    = 80;
   localparam int RANDOM_ITEMS   = 800;
   localparam int QUIET_ITEMS    = 120;
   localparam int NUM_DIRECTED   = 22;

   // Encodings outside the supported set, and the only legal jalr function.
   localparam logic [4:0] OP_UNKNOWN = 5'b00001;
   localparam logic [2:0] F3_LD_RSVD = 3'd3;
   localparam logic [2:0] F3_BR_RSVD = 3'd2;
   localparam logic [2:0] F3_JALR    = 3'd0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_instr_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_next_pc;
   logic [4:0]  rsp_dest_index;
   logic [31:0] rsp_dest_value;
   logic        rsp_dest_written;
   logic [1:0]  rsp_exec_status;

   // Architectural state mirrored by the predictor.
   logic [31:0] arch_regs [NUM_REGS];
   logic [31:0] arch_mem [MEM_WORDS];
   logic [31:0] arch_pc;
   logic        arch_halted;

   ric_rsp_type pending_rsp [$];
   int          error_count = 0;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;
   bit          hold_off = 1'b0;

   logic [31:0] dir_word  [NUM_DIRECTED];
   bit          dir_typed [NUM_DIRECTED];
   ric_rsp_type dir_rsp   [NUM_DIRECTED];

   rv32i_instruction_execute uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_instr_word(req_instr_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_next_pc(rsp_next_pc),
      .rsp_dest_index(rsp_dest_index), .rsp_dest_value(rsp_dest_value),
      .rsp_dest_written(rsp_dest_written), .rsp_exec_status(rsp_exec_status)
   );

   always #6 clock = ~clock;

   function automatic logic [31:0] reg_read(input logic [4:0] idx);
      return (idx == 5'd0) ? 32'd0 : arch_regs[idx];
   endfunction

   function automatic int word_of(input logic [31:0] addr);
      return int'((addr >> 2) % MEM_WORDS);
   endfunction

   function automatic logic signed_less(input logic [31:0] x, input logic [31:0] y);
      return $signed(x) < $signed(y);
   endfunction

   // Executes one instruction on the mirrored state and returns its result.
   function automatic ric_rsp_type execute_instr(input logic [31:0] ins);
      ric_rsp_type r;
      logic [4:0]  op, rd;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] a, b, imm_i, addr, val, nxt, w, off;
      logic [1:0]  st;
      logic        wr, take;
      int          idx;
      op = ins[6:2];
      rd = ins[11:7];
      f3 = ins[14:12];
      f7 = ins[31:25];
      a = reg_read(ins[19:15]);
      b = reg_read(ins[24:20]);
      imm_i = {{20{ins[31]}}, ins[31:20]};
      nxt = arch_pc + 32'd4;
      val = '0;
      wr = 1'b0;
      st = ST_OK;
      r = '0;
      if (arch_halted) begin
         r.next_pc = arch_pc;
         return r;
      end
      case (op)
         OP_LOAD: begin
            addr = a + imm_i;
            if (f3 == F3_LD_RSVD || f3 > F3_HU) begin
               st = ST_ILLEGAL;
            end else begin
               if (f3 == F3_W) begin
                  val = arch_mem[word_of(addr)];
               end else if (f3 == F3_B || f3 == F3_BU) begin
                  w = arch_mem[word_of(addr)];
                  val = (w >> (addr[1:0] * 8)) & 32'hff;
                  if (f3 == F3_B) val = {{24{val[7]}}, val[7:0]};
               end else begin
                  w = arch_mem[word_of(addr)];
                  val = (w >> (addr[1] * 16)) & 32'hffff;
                  if (f3 == F3_H) val = {{16{val[15]}}, val[15:0]};
               end
               wr = 1'b1;
            end
         end
         OP_FENCE, OP_SYSTEM: st = ST_SYSTEM;
         OP_IMM: begin
            case (f3)
               F3_ADD:  val = a + imm_i;
               F3_SLL:  if (f7 != F7_ZERO) st = ST_ILLEGAL; else val = a << ins[24:20];
               F3_SLT:  val = {31'd0, signed_less(a, imm_i)};
               F3_SLTU: val = {31'd0, a < imm_i};
               F3_XOR:  val = a ^ imm_i;
               F3_SR: begin
                  if (f7 == F7_ZERO) val = a >> ins[24:20];
                  else if (f7 == F7_ALT) val = 32'($signed(a) >>> ins[24:20]);
                  else st = ST_ILLEGAL;
               end
               F3_OR:   val = a | imm_i;
               default: val = a & imm_i;
            endcase
            wr = (st == ST_OK);
         end
         OP_AUIPC: begin
            val = arch_pc + {ins[31:12], 12'd0};
            wr = 1'b1;
         end
         OP_STORE: begin
            addr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
            idx = word_of(addr);
            if (f3 > F3_W) st = ST_ILLEGAL;
            else if (f3 == F3_W) arch_mem[idx] = b;
            else if (f3 == F3_H) begin
               if (addr[1]) arch_mem[idx][31:16] = b[15:0];
               else arch_mem[idx][15:0] = b[15:0];
            end else begin
               case (addr[1:0])
                  2'd0: arch_mem[idx][7:0]   = b[7:0];
                  2'd1: arch_mem[idx][15:8]  = b[7:0];
                  2'd2: arch_mem[idx][23:16] = b[7:0];
                  default: arch_mem[idx][31:24] = b[7:0];
               endcase
            end
         end
         OP_REG: begin
            if (f7 != F7_ZERO && !(f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
               st = ST_ILLEGAL;
            end else begin
               case (f3)
                  F3_ADD:  val = (f7 != F7_ZERO) ? a - b : a + b;
                  F3_SLL:  val = a << b[4:0];
                  F3_SLT:  val = {31'd0, signed_less(a, b)};
                  F3_SLTU: val = {31'd0, a < b};
                  F3_XOR:  val = a ^ b;
                  F3_SR:   val = (f7 != F7_ZERO) ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
                  F3_OR:   val = a | b;
                  default: val = a & b;
               endcase
               wr = 1'b1;
            end
         end
         OP_LUI: begin
            val = {ins[31:12], 12'd0};
            wr = 1'b1;
         end
         OP_BRANCH: begin
            off = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
            take = 1'b0;
            case (f3)
               BR_EQ:   take = (a == b);
               BR_NE:   take = (a != b);
               BR_LT:   take = signed_less(a, b);
               BR_GE:   take = !signed_less(a, b);
               BR_LTU:  take = (a < b);
               BR_GEU:  take = (a >= b);
               default: st = ST_ILLEGAL;
            endcase
            if (take) nxt = arch_pc + off;
         end
         OP_JALR: begin
            if (f3 != F3_JALR) begin
               st = ST_ILLEGAL;
            end else begin
               val = arch_pc + 32'd4;
               nxt = (a + imm_i) & ~32'd1;
               wr = 1'b1;
            end
         end
         OP_JAL: begin
            val = arch_pc + 32'd4;
            nxt = arch_pc + {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
            wr = 1'b1;
         end
         default: st = ST_ILLEGAL;
      endcase
      if (st != ST_OK) begin
         arch_halted = 1'b1;
         nxt = arch_pc;
         wr = 1'b0;
      end
      if (wr && rd != 5'd0) arch_regs[rd] = val;
      else wr = 1'b0;
      arch_pc = nxt;
      r.next_pc = nxt;
      r.dest_index = wr ? rd : 5'd0;
      r.dest_value = wr ? val : 32'd0;
      r.dest_written = wr;
      r.exec_status = st;
      return r;
   endfunction

   function automatic logic [31:0] enc_i(input logic [4:0] op, input logic [2:0] f3,
                                         input logic [4:0] rd, input logic [4:0] rs1,
                                         input logic [11:0] imm);
      return {imm, rs1, f3, rd, op, 2'b11};
   endfunction

   function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [2:0] f3,
                                         input logic [4:0] rd, input logic [4:0] rs1,
                                         input logic [4:0] rs2);
      return {f7, rs2, rs1, f3, rd, OP_REG, 2'b11};
   endfunction

   function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                         input logic [4:0] rs2, input logic [11:0] imm);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE, 2'b11};
   endfunction

   // A well-formed instruction with random content; memory bases favour x0 so that
   // addresses meet again.
   function automatic logic [31:0] random_legal();
      logic [31:0] w;
      logic [2:0]  ld_f3 [5];
      int          kind;
      ld_f3 = '{F3_B, F3_H, F3_W, F3_BU, F3_HU};
      w = $urandom;
      kind = $urandom_range(0, 9);
      case (kind)
         0: begin
            w[6:2] = OP_LOAD;
            w[14:12] = ld_f3[$urandom_range(0, 4)];
            if ($urandom_range(0, 1)) w[19:15] = 5'd0;
         end
         1: begin
            w[6:2] = OP_STORE;
            w[14:12] = 3'($urandom_range(0, 2));
            if ($urandom_range(0, 1)) w[19:15] = 5'd0;
         end
         2, 3: begin
            w[6:2] = OP_IMM;
            if (w[14:12] == F3_SLL) w[31:25] = F7_ZERO;
            if (w[14:12] == F3_SR) w[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_ZERO;
         end
         4: begin
            w[6:2] = OP_REG;
            if ((w[14:12] == F3_ADD || w[14:12] == F3_SR) && $urandom_range(0, 1))
               w[31:25] = F7_ALT;
            else
               w[31:25] = F7_ZERO;
         end
         5: w[6:2] = $urandom_range(0, 1) ? OP_LUI : OP_AUIPC;
         6: begin
            w[6:2] = OP_BRANCH;
            w[14:12] = ld_f3[$urandom_range(0, 4)] == F3_W ? BR_GEU : 3'($urandom_range(4, 7));
            if ($urandom_range(0, 2) == 0) w[14:12] = $urandom_range(0, 1) ? BR_NE : BR_EQ;
         end
         7: begin
            w[6:2] = OP_JALR;
            w[14:12] = F3_JALR;
         end
         8: w[6:2] = OP_JAL;
         default: begin
            w[6:2] = OP_IMM;
            w[14:12] = F3_ADD;
         end
      endcase
      return w;
   endfunction

   // Offers one item, holding it until accepted, then maybe idles.
   task automatic send_item(input logic [31:0] word, input bit typed, input ric_rsp_type exp);
      ric_rsp_type pred;
      req_valid = 1'b1;
      req_instr_word = word;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      pred = execute_instr(word);
      pending_rsp.push_back(typed ? exp : pred);
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // Receiver: random stall bursts, a long hold-off on request, none when quiet.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_off = 1'b0;
            rsp_stall = 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 3) - 1) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // Result checker and watchdog.
   always @(posedge clock) begin
      ric_rsp_type got, exp;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_next_pc, rsp_dest_index, rsp_dest_value, rsp_dest_written,
                 rsp_exec_status};
         if (pending_rsp.size() == 0) begin
            error_count++;
            if (error_count <= 10) $display("unexpected result item: %h", got);
         end else begin
            exp = pending_rsp.pop_front();
            if (got !== exp) begin
               error_count++;
               if (error_count <= 10)
                  $display({"mismatch: expected pc %h rd %0d val %h wr %b st %0d, ",
                            "got pc %h rd %0d val %h wr %b st %0d"},
                           exp.next_pc, exp.dest_index, exp.dest_value, exp.dest_written,
                           exp.exec_status, got.next_pc, got.dest_index, got.dest_value,
                           got.dest_written, got.exec_status);
            end
         end
      end
   end

   initial begin
      ric_rsp_type none;
      logic [31:0] w;
      none = '0;
      foreach (arch_regs[i]) arch_regs[i] = '0;
      foreach (arch_mem[i]) arch_mem[i] = '0;
      arch_pc = '0;
      arch_halted = 1'b0;

      // Directed table; the first rows carry expectations read straight off the encoding.
      foreach (dir_typed[i]) begin
         dir_typed[i] = 1'b0;
         dir_rsp[i] = '0;
      end
      dir_word[0] = 32'hfff00093;   // addi x1, x0, -1
      dir_typed[0] = 1'b1;
      dir_rsp[0] = '{32'd4, 5'd1, 32'hffffffff, 1'b1, ST_OK};
      dir_word[1] = 32'hfffff137;   // lui x2, 0xfffff
      dir_typed[1] = 1'b1;
      dir_rsp[1] = '{32'd8, 5'd2, 32'hfffff000, 1'b1, ST_OK};
      dir_word[2] = 32'h00508010;   // addi x0, x1, 5 with low opcode bits clear
      dir_typed[2] = 1'b1;
      dir_rsp[2] = '{32'd12, 5'd0, 32'd0, 1'b0, ST_OK};
      // Store at address -4 wraps to the top word; partial accesses align down.
      dir_word[3]  = enc_s(F3_W, 5'd0, 5'd2, 12'hffc);
      dir_word[4]  = enc_i(OP_LOAD, F3_W, 5'd3, 5'd0, 12'hfff);
      dir_word[5]  = enc_i(OP_LOAD, F3_B, 5'd4, 5'd0, 12'hfff);
      dir_word[6]  = enc_i(OP_LOAD, F3_BU, 5'd5, 5'd0, 12'hffe);
      dir_word[7]  = enc_i(OP_LOAD, F3_H, 5'd6, 5'd0, 12'hfff);
      dir_word[8]  = enc_i(OP_LOAD, F3_HU, 5'd7, 5'd0, 12'hffd);
      dir_word[9]  = enc_s(F3_H, 5'd0, 5'd1, 12'h003);
      dir_word[10] = enc_s(F3_B, 5'd0, 5'd2, 12'h001);
      dir_word[11] = enc_i(OP_LOAD, F3_W, 5'd8, 5'd0, 12'h002);
      dir_word[12] = enc_i(OP_IMM, F3_SR, 5'd9, 5'd2, {F7_ALT, 5'd31});
      dir_word[13] = enc_i(OP_IMM, F3_SR, 5'd10, 5'd2, {F7_ZERO, 5'd31});
      dir_word[14] = enc_r(F7_ALT, F3_ADD, 5'd11, 5'd0, 5'd1);
      dir_word[15] = enc_r(F7_ZERO, F3_SLT, 5'd12, 5'd2, 5'd0);
      dir_word[16] = enc_r(F7_ZERO, F3_SLTU, 5'd13, 5'd2, 5'd0);
      dir_word[17] = enc_r(F7_ALT, F3_SR, 5'd14, 5'd2, 5'd11);
      dir_word[18] = {1'b1, 6'h3f, 5'd1, 5'd1, BR_EQ, 4'hf, 1'b1, OP_BRANCH, 2'b11};
      dir_word[19] = {20'h80000, 5'd15, OP_JAL, 2'b11};
      dir_word[20] = enc_i(OP_JALR, F3_JALR, 5'd16, 5'd1, 12'h7ff);
      dir_word[21] = {20'hfffff, 5'd17, OP_AUIPC, 2'b11};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < NUM_DIRECTED; i++) send_item(dir_word[i], dir_typed[i], dir_rsp[i]);

      // Pause the sender until everything has come back.
      wait_drained();

      // Long receiver hold-off while the sender keeps offering items.
      hold_off = 1'b1;
      for (int i = 0; i < 30; i++) send_item(random_legal(), 1'b0, none);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         send_item(random_legal(), 1'b0, none);
      end

      // One halting instruction, then a few items that must be ignored.
      w = $urandom;
      case ($urandom_range(0, 4))
         0: w[6:2] = OP_FENCE;
         1: w[6:2] = OP_SYSTEM;
         2: w[6:2] = OP_UNKNOWN;
         3: begin
            w[6:2] = OP_LOAD;
            w[14:12] = F3_LD_RSVD;
         end
         default: begin
            w[6:2] = OP_BRANCH;
            w[14:12] = F3_BR_RSVD;
         end
      endcase
      send_item(w, 1'b0, none);
      for (int i = 0; i < 6; i++) send_item($urandom, 1'b0, none);

      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
design/ric_pkg.sv
design/ric_regfile.sv
design/ric_dmem.sv
design/ric_exec.sv
design/ric_rspq.sv
design/rv32i_instruction_execute.sv
design/ric_checker.sv
sim/tb_rv32i_instruction_execute.sv
